[src/payload_compare_filter_unit_assert.svh]
// Assertion helpers shared by the filter's modules.
// The enclosing module must have clk_i and rst_ni.
`ifndef PAYLOAD_COMPARE_FILTER_UNIT_ASSERT_SVH
`define PAYLOAD_COMPARE_FILTER_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define PCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("payload compare filter: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PCF_ASSERT_NEXT(lbl, ante, cons) `PCF_ASSERT(lbl, (ante) |=> (cons))

`endif

[src/pcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

  localparam int unsigned PatternBytes = 32;
  localparam int unsigned PatWords     = 4;
  localparam int unsigned WordW        = 64;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned PLenW        = 6;
  localparam int unsigned CntW         = 6;
  localparam int unsigned PIdxW        = (PatternBytes > 1) ? $clog2(PatternBytes) : 1;
  localparam int unsigned AddrW        = 6;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW        = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    REG_COMPARE_OP      = 3'd0,
    REG_PATTERN_LENGTH  = 3'd1,
    REG_PATTERN_WORD_0  = 3'd2,
    REG_PATTERN_WORD_1  = 3'd3,
    REG_PATTERN_WORD_2  = 3'd4,
    REG_PATTERN_WORD_3  = 3'd5,
    REG_ACTION_IF_TRUE  = 3'd6,
    REG_ACTION_IF_FALSE = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMP_EQ       = 3'd0,
    CMP_NE       = 3'd1,
    CMP_LT       = 3'd2,
    CMP_LE       = 3'd3,
    CMP_GT       = 3'd4,
    CMP_GE       = 3'd5,
    CMP_CONTAINS = 3'd6
  } cmp_op_e;

  typedef enum logic [1:0] {
    ACT_PASS    = 2'd0,
    ACT_DISCARD = 2'd1,
    ACT_LITERAL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ORD_EQ      = 2'd0,
    ORD_LESS    = 2'd1,
    ORD_GREATER = 2'd2
  } ord_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             last_byte;
    logic             empty_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       condition_met;
  } out_item_t;

  // Register view handed to the datapath, with the pattern pre-aligned
  // for the window compare.
  typedef struct packed {
    logic [2:0]                         compare_op;
    logic [PLenW-1:0]                   plen;
    logic [PatternBytes-1:0][ByteW-1:0] pat;
    logic [PatternBytes-1:0][ByteW-1:0] aligned;
    logic [PatternBytes-1:0]            mask;
    logic [1:0]                         action_if_true;
    logic [1:0]                         action_if_false;
  } cfg_t;

endpackage

`default_nettype wire

[src/pcf_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcf_regs import pcf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [WordW-1:0] pwdata,
  output logic      [WordW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [2:0]                   compare_op_q;
  logic [PLenW-1:0]             pattern_length_q;
  logic [PatWords-1:0][WordW-1:0] pattern_word_q;
  logic [1:0]                   act_true_q;
  logic [1:0]                   act_false_q;
  logic                         wr_en;
  reg_idx_e                     idx;
  logic [PLenW-1:0]             plen;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_op_q     <= CMP_EQ;
      pattern_length_q <= '0;
      pattern_word_q   <= '0;
      act_true_q       <= ACT_PASS;
      act_false_q      <= ACT_DISCARD;
    end else if (wr_en) begin
      case (idx)
        REG_COMPARE_OP:      compare_op_q      <= pwdata[2:0];
        REG_PATTERN_LENGTH:  pattern_length_q  <= pwdata[PLenW-1:0];
        REG_PATTERN_WORD_0:  pattern_word_q[0] <= pwdata;
        REG_PATTERN_WORD_1:  pattern_word_q[1] <= pwdata;
        REG_PATTERN_WORD_2:  pattern_word_q[2] <= pwdata;
        REG_PATTERN_WORD_3:  pattern_word_q[3] <= pwdata;
        REG_ACTION_IF_TRUE:  act_true_q        <= pwdata[1:0];
        REG_ACTION_IF_FALSE: act_false_q       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_COMPARE_OP:      prdata = WordW'(compare_op_q);
      REG_PATTERN_LENGTH:  prdata = WordW'(pattern_length_q);
      REG_PATTERN_WORD_0:  prdata = pattern_word_q[0];
      REG_PATTERN_WORD_1:  prdata = pattern_word_q[1];
      REG_PATTERN_WORD_2:  prdata = pattern_word_q[2];
      REG_PATTERN_WORD_3:  prdata = pattern_word_q[3];
      REG_ACTION_IF_TRUE:  prdata = WordW'(act_true_q);
      REG_ACTION_IF_FALSE: prdata = WordW'(act_false_q);
      default:             prdata = '0;
    endcase
  end

  // lengths beyond the pattern store clamp to its size
  assign plen = (pattern_length_q > PLenW'(PatternBytes)) ? PLenW'(PatternBytes)
                                                          : pattern_length_q;

  // aligned[k] is the pattern byte that must sit k places behind the newest byte
  always_comb begin
    logic [PLenW-1:0] src;
    src = '0;
    for (int k = 0; k < PatternBytes; k++) begin
      cfg_o.pat[k] = pattern_word_q[k / 8][(k % 8) * ByteW +: ByteW];
    end
    for (int k = 0; k < PatternBytes; k++) begin
      src              = plen - PLenW'(k) - PLenW'(1);
      cfg_o.aligned[k] = cfg_o.pat[src[PIdxW-1:0]];
      cfg_o.mask[k]    = PLenW'(k) < plen;
    end
    cfg_o.compare_op      = compare_op_q;
    cfg_o.plen            = plen;
    cfg_o.action_if_true  = act_true_q;
    cfg_o.action_if_false = act_false_q;
  end

endmodule

`default_nettype wire

[src/pcf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "payload_compare_filter_unit_assert.svh"

module pcf_front import pcf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  output logic          in_stall_o,
  input  wire logic     q_full_i,
  output logic          push_o,
  output logic          push_cond_o
);

  ord_e                               ord_q, ord_n, j_ord, ord_eff;
  logic [CntW-1:0]                    bytes_q, bytes_n, j_bytes;
  logic                               match_q, match_n, j_match;
  logic [PatternBytes-1:0][ByteW-1:0] win_q, win_n;
  logic [PatternBytes-1:0]            eq_vec;
  logic [ByteW-1:0]                   b, pbyte;
  logic                               accept, pkt_end, hit, cond;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign pkt_end    = in_data_i.empty_packet | in_data_i.last_byte;
  assign b          = in_data_i.payload_byte;
  assign pbyte      = cfg_i.pat[bytes_q[PIdxW-1:0]];

  always_comb begin
    ord_n = ord_q;
    if (ord_q == ORD_EQ) begin
      if (CntW'(cfg_i.plen) > bytes_q) begin
        if (b < pbyte) begin
          ord_n = ORD_LESS;
        end else if (b > pbyte) begin
          ord_n = ORD_GREATER;
        end
      end else begin
        ord_n = ORD_GREATER;
      end
    end
  end

  assign bytes_n = (bytes_q != {CntW{1'b1}}) ? bytes_q + CntW'(1) : bytes_q;

  always_comb begin
    win_n[0] = b;
    for (int k = 1; k < PatternBytes; k++) begin
      win_n[k] = win_q[k-1];
    end
    for (int k = 0; k < PatternBytes; k++) begin
      eq_vec[k] = ~cfg_i.mask[k] | (win_n[k] == cfg_i.aligned[k]);
    end
  end

  assign hit     = (cfg_i.plen != '0) && (bytes_n >= CntW'(cfg_i.plen)) && (&eq_vec);
  assign match_n = match_q | hit;

  // an empty packet is judged from the cleared state
  assign j_ord   = in_data_i.empty_packet ? ORD_EQ : ord_n;
  assign j_bytes = in_data_i.empty_packet ? '0 : bytes_n;
  assign j_match = in_data_i.empty_packet ? 1'b0 : match_n;

  // a payload that is a strict prefix of the pattern sorts first
  assign ord_eff = ((j_ord == ORD_EQ) && (j_bytes < CntW'(cfg_i.plen))) ? ORD_LESS : j_ord;

  always_comb begin
    case (cfg_i.compare_op)
      CMP_EQ:       cond = ord_eff == ORD_EQ;
      CMP_NE:       cond = ord_eff != ORD_EQ;
      CMP_LT:       cond = ord_eff == ORD_LESS;
      CMP_LE:       cond = ord_eff != ORD_GREATER;
      CMP_GT:       cond = ord_eff == ORD_GREATER;
      CMP_GE:       cond = ord_eff != ORD_LESS;
      CMP_CONTAINS: cond = (cfg_i.plen == '0) | j_match;
      default:      cond = 1'b0;
    endcase
  end

  assign push_o      = accept & pkt_end;
  assign push_cond_o = cond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q   <= ORD_EQ;
      bytes_q <= '0;
      match_q <= 1'b0;
    end else if (accept) begin
      if (pkt_end) begin
        ord_q   <= ORD_EQ;
        bytes_q <= '0;
        match_q <= 1'b0;
      end else begin
        ord_q   <= ord_n;
        bytes_q <= bytes_n;
        match_q <= match_n;
      end
    end
  end

  // window slots beyond bytes_q are never compared, so no clearing is needed
  always_ff @(posedge clk_i) begin
    if (accept && !in_data_i.empty_packet) begin
      win_q <= win_n;
    end
  end

  `PCF_ASSERT_NEXT(a_front_clear, accept && pkt_end,
                   (bytes_q == '0) && (ord_q == ORD_EQ) && !match_q)
  `PCF_ASSERT(a_front_no_push_full, push_o |-> !q_full_i)

endmodule

`default_nettype wire

[src/pcf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "payload_compare_filter_unit_assert.svh"

module pcf_queue import pcf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire logic data_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output logic      data_o
);

  logic [QueueDepth-1:0] mem_q;
  logic [QPtrW-1:0]      wr_q, rd_q;
  logic [QCntW-1:0]      count_q;

  assign full_o  = count_q == QCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `PCF_ASSERT_NEXT(a_q_inc, push_i && !pop_i, count_q == $past(count_q) + QCntW'(1))
  `PCF_ASSERT(a_q_pop_valid, pop_i |-> valid_o)

endmodule

`default_nettype wire

[src/pcf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "payload_compare_filter_unit_assert.svh"

module pcf_back import pcf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic q_valid_i,
  input  wire logic q_cond_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  logic       out_valid_q;
  out_item_t  out_data_q;
  logic [1:0] act;
  logic [1:0] act_true_map;

  function automatic logic [1:0] map_action(input logic [1:0] a);
    logic [1:0] r;
    r = ACT_DISCARD;
    if (a == ACT_PASS || a == ACT_LITERAL) begin
      r = a;
    end
    return r;
  endfunction

  assign pop_o        = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign act          = q_cond_i ? cfg_i.action_if_true : cfg_i.action_if_false;
  assign act_true_map = map_action(cfg_i.action_if_true);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= pop_o | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q.verdict       <= map_action(act);
      out_data_q.condition_met <= q_cond_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PCF_ASSERT_NEXT(a_back_load, pop_o, out_valid_q)
  `PCF_ASSERT(a_back_true_branch, out_valid_q && out_data_q.condition_met
              |-> out_data_q.verdict == act_true_map)

endmodule

`default_nettype wire

[src/payload_compare_filter_unit.sv]
// Payload compare filter: judges each packet's payload against a pattern of
// up to 32 bytes and returns one verdict per packet.
// Input channel: one payload byte per transfer (in_valid_i / in_stall_o),
// last_byte closes the packet; a transfer with empty_packet set stands for
// a whole zero-byte packet. Output channel: one verdict and condition flag
// per packet (out_valid_o / out_stall_i), nothing for the other bytes.
// Registers sit on the APB port at 8-byte spacing, 64-bit data.
// Throughput: one byte per cycle while in_stall_o is low; the 32-byte window
// compare and order update in the front end are combinational.
// Path to the output: the front end writes each verdict into a 2-entry
// queue, then the back end loads it into the output register that drives
// out_valid_o.
// When the receiver stalls, up to two verdicts wait in the queue and one in
// the output register; bytes of later packets are taken until the queue
// fills, then in_stall_o rises.
// Reset clears the per-packet state, empties the queue and loads the
// register defaults (compare equal, empty pattern, forward / drop).
`timescale 1ns / 1ps
`default_nettype none

module payload_compare_filter_unit import pcf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire in_item_t         in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output out_item_t             out_data_o,
  input  wire logic             out_stall_i,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [WordW-1:0] pwdata,
  output logic      [WordW-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic q_full, q_valid, q_cond, push, push_cond, pop;

  pcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cond_o (push_cond)
  );

  pcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cond),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_cond)
  );

  pcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_cond_i    (q_cond),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
